// ----- rtl/gfba_pkg.sv -----
// gfba_pkg: shared constants, word types and sequencer states for the
// grouped free block allocator. No dependencies.
package gfba_pkg;

  // sizes fixed by the word formats
  localparam int GROUP_SIZE_DEF = 50;
  localparam int BLOCK_COUNT    = 1024;
  localparam int BLK_W          = 10;
  localparam int NUM_W          = 11;

  // stack value that terminates the chain of groups
  localparam logic [NUM_W-1:0] END_MARK = NUM_W'(BLOCK_COUNT);

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // status codes
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FAIL = 1'b1;

  // request word
  typedef struct packed {
    logic             command;
    logic [BLK_W-1:0] block_number;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [BLK_W-1:0] granted_block;
    logic             status;
    logic [NUM_W-1:0] free_count;
  } out_word_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_POP,
    S_BOTTOM,
    S_REFILL,
    S_SPILL
  } state_t;

endpackage

// ----- rtl/gfba_ram.sv -----
// gfba_ram: generic simple dual-port RAM, one write and one registered read.
// Used for the number stack and the group store. No dependencies.
module gfba_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/grouped_free_block_allocator.sv -----
// grouped_free_block_allocator: top level, sequencer around the number
// stack RAM and the group store RAM. Depends on gfba_pkg and gfba_ram.
//
//   channel  ports                     handshake
//   -------  ------------------------  -----------------------------------
//   request  start, busy, in_word      taken at an edge with start && !busy
//   result   out_valid, out_word       one-cycle strobe, cannot be held off
//
// A free onto a non-full stack answers in the next cycle; an allocate waits
// for the registered read of the stack RAM before its result is registered.
// A free on a full stack spills the stack into the group store, one entry
// a cycle. An allocate of a group leader refills the stack from the group
// store the same way. After reset the S_INIT state writes the end marker
// to the stack bottom; busy is high meanwhile. The receiver cannot stall
// the block.
module grouped_free_block_allocator #(
  parameter int GROUP_SIZE = gfba_pkg::GROUP_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  gfba_pkg::in_word_t  in_word,
  output logic                out_valid,
  output gfba_pkg::out_word_t out_word
);
  import gfba_pkg::*;

  localparam int SW     = $clog2(GROUP_SIZE);
  localparam int CW     = $clog2(GROUP_SIZE + 1);
  localparam int GDEPTH = BLOCK_COUNT * GROUP_SIZE;
  localparam int GW     = $clog2(GDEPTH);

  localparam logic [SW-1:0]    LAST_IDX = SW'(GROUP_SIZE - 1);
  localparam logic [CW-1:0]    FULL_CNT = CW'(GROUP_SIZE);
  localparam logic [NUM_W-1:0] MAX_FREE = NUM_W'(BLOCK_COUNT);

  // registers
  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [NUM_W-1:0] free_r, free_nxt;
  logic [SW-1:0]    cnt_r, cnt_nxt;
  logic [SW-1:0]    idx_r, idx_nxt;
  logic             iss_r, iss_nxt;
  logic             pend_r, pend_nxt;
  logic [GW-1:0]    base_r, base_nxt;
  logic [BLK_W-1:0] leader_r, leader_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  // memory ports
  logic             stk_we, stk_re;
  logic [SW-1:0]    stk_waddr, stk_raddr;
  logic [NUM_W-1:0] stk_wdata, stk_rdata;
  logic             grp_we, grp_re;
  logic [GW-1:0]    grp_waddr, grp_raddr;
  logic [NUM_W-1:0] grp_wdata, grp_rdata;

  // helpers
  logic             accept;
  logic             blk_ok;
  logic             stk_is_mark;
  logic             last_issue;
  logic             last_data;
  logic [NUM_W-1:0] free_dec, free_inc;
  logic [BLK_W-1:0] mul_src;
  logic [GW-1:0]    base_mul;

  gfba_ram #(
    .WIDTH (NUM_W),
    .DEPTH (GROUP_SIZE)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  gfba_ram #(
    .WIDTH (NUM_W),
    .DEPTH (GDEPTH)
  ) u_group_ram (
    .clk   (clk),
    .we    (grp_we),
    .waddr (grp_waddr),
    .wdata (grp_wdata),
    .re    (grp_re),
    .raddr (grp_raddr),
    .rdata (grp_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // shared terms
  assign blk_ok      = NUM_W'(in_word.block_number) < END_MARK;
  assign stk_is_mark = stk_rdata >= END_MARK;
  assign last_issue  = iss_r && (cnt_r == LAST_IDX);
  assign last_data   = pend_r && (idx_r == LAST_IDX);
  assign free_dec    = (free_r != '0) ? free_r - NUM_W'(1) : free_r;
  assign free_inc    = (free_r < MAX_FREE) ? free_r + NUM_W'(1) : free_r;

  // group base address, one constant multiply shared by spill and refill
  assign mul_src  = (state_r == S_BOTTOM) ? stk_rdata[BLK_W-1:0] : in_word.block_number;
  assign base_mul = GW'(mul_src) * GW'(GROUP_SIZE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (in_word.command == CMD_ALLOC) begin
            state_nxt = (count_r <= CW'(1)) ? S_BOTTOM : S_POP;
          end else if (blk_ok && count_r == FULL_CNT) begin
            state_nxt = S_SPILL;
          end
        end
      end
      S_POP:    state_nxt = S_IDLE;
      S_BOTTOM: state_nxt = stk_is_mark ? S_IDLE : S_REFILL;
      S_REFILL: state_nxt = last_data ? S_IDLE : S_REFILL;
      S_SPILL:  state_nxt = last_data ? S_IDLE : S_SPILL;
      default:  state_nxt = S_INIT;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    count_nxt     = count_r;
    free_nxt      = free_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    iss_nxt       = iss_r;
    pend_nxt      = pend_r;
    base_nxt      = base_r;
    leader_nxt    = leader_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    stk_we        = 1'b0;
    stk_waddr     = '0;
    stk_wdata     = '0;
    stk_re        = 1'b0;
    stk_raddr     = '0;
    grp_we        = 1'b0;
    grp_waddr     = '0;
    grp_wdata     = '0;
    grp_re        = 1'b0;
    grp_raddr     = '0;

    unique case (state_r)
      // put the end marker at the stack bottom
      S_INIT: begin
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = END_MARK;
      end

      S_IDLE: begin
        if (accept) begin
          if (in_word.command == CMD_ALLOC) begin
            // read the top entry
            stk_re    = 1'b1;
            stk_raddr = SW'(count_r - CW'(1));
            count_nxt = (count_r > CW'(1)) ? count_r - CW'(1) : CW'(1);
          end else if (!blk_ok) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{granted_block: '0, status: STAT_OK, free_count: free_r};
          end else if (count_r < FULL_CNT) begin
            // plain push
            stk_we        = 1'b1;
            stk_waddr     = SW'(count_r);
            stk_wdata     = NUM_W'(in_word.block_number);
            count_nxt     = count_r + CW'(1);
            free_nxt      = free_inc;
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{granted_block: '0, status: STAT_OK, free_count: free_inc};
          end else begin
            // full stack: start the spill into the freed block's group
            base_nxt   = base_mul;
            leader_nxt = in_word.block_number;
            cnt_nxt    = '0;
            iss_nxt    = 1'b1;
            pend_nxt   = 1'b0;
          end
        end
      end

      S_POP: begin
        free_nxt      = free_dec;
        out_valid_nxt = 1'b1;
        out_word_nxt  = '{granted_block: stk_rdata[BLK_W-1:0], status: STAT_OK,
                          free_count: free_dec};
      end

      // last entry: end marker fails, a leader starts the refill
      S_BOTTOM: begin
        if (stk_is_mark) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{granted_block: '0, status: STAT_FAIL, free_count: free_r};
        end else begin
          base_nxt   = base_mul;
          leader_nxt = stk_rdata[BLK_W-1:0];
          cnt_nxt    = '0;
          iss_nxt    = 1'b1;
          pend_nxt   = 1'b0;
        end
      end

      // group slot j goes to stack position GROUP_SIZE-1-j
      S_REFILL: begin
        if (iss_r) begin
          grp_re    = 1'b1;
          grp_raddr = base_r + GW'(cnt_r);
          cnt_nxt   = last_issue ? cnt_r : cnt_r + SW'(1);
          iss_nxt   = !last_issue;
        end
        pend_nxt = iss_r;
        idx_nxt  = cnt_r;
        if (pend_r) begin
          stk_we    = 1'b1;
          stk_waddr = LAST_IDX - idx_r;
          stk_wdata = grp_rdata;
        end
        if (last_data) begin
          count_nxt     = FULL_CNT;
          free_nxt      = free_dec;
          pend_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{granted_block: leader_r, status: STAT_OK, free_count: free_dec};
        end
      end

      // stack entries top-first into group slots, then restart the stack
      S_SPILL: begin
        if (iss_r) begin
          stk_re    = 1'b1;
          stk_raddr = LAST_IDX - cnt_r;
          cnt_nxt   = last_issue ? cnt_r : cnt_r + SW'(1);
          iss_nxt   = !last_issue;
        end
        pend_nxt = iss_r;
        idx_nxt  = cnt_r;
        if (pend_r) begin
          grp_we    = 1'b1;
          grp_waddr = base_r + GW'(idx_r);
          grp_wdata = stk_rdata;
        end
        if (last_data) begin
          stk_we        = 1'b1;
          stk_waddr     = '0;
          stk_wdata     = NUM_W'(leader_r);
          count_nxt     = CW'(1);
          free_nxt      = free_inc;
          pend_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{granted_block: '0, status: STAT_OK, free_count: free_inc};
        end
      end

      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      count_r     <= CW'(1);
      free_r      <= '0;
      iss_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      free_r      <= free_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    base_r     <= base_nxt;
    leader_r   <= leader_nxt;
    out_word_r <= out_word_nxt;
  end

  // an allocate never finishes in its accept cycle
  a_alloc_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_word.command == CMD_ALLOC |=> busy && !out_valid)
    else $error("allocate finished without a stack read");

  // a push onto a non-full stack answers in the next cycle
  a_push_answers: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_word.command == CMD_FREE && count_r < FULL_CNT |=> out_valid && !busy)
    else $error("push result missing");

  // a failed allocate grants nothing and leaves a single stack entry
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == STAT_FAIL |-> out_word.granted_block == '0 &&
      count_r == CW'(1))
    else $error("failed allocate left state behind");

  // the stack count stays within one to GROUP_SIZE
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> count_r >= CW'(1) && count_r <= FULL_CNT)
    else $error("stack count out of range");

  // a finished refill leaves the stack full
  a_refill_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(state_r) == S_REFILL |-> count_r == FULL_CNT)
    else $error("refill did not fill the stack");

endmodule
